FILE: hdl/atdr_pkg.sv
// Shared types and constants of the averaged tension deadband regulator.
package atdr_pkg;

   // Request mode codes
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_STOP   = 2'd2;

   // Register indexes on the control port
   localparam int         CSR_IDX_W      = 3;
   localparam int         CSR_DATA_W     = 24;
   localparam logic [2:0] CSR_TARGET     = 3'd0;
   localparam logic [2:0] CSR_DEADBAND   = 3'd1;
   localparam logic [2:0] CSR_STEP       = 3'd2;
   localparam logic [2:0] CSR_BRAKE_MIN  = 3'd3;
   localparam logic [2:0] CSR_BRAKE_MAX  = 3'd4;
   localparam logic [2:0] CSR_FEEDER     = 3'd5;

   // Register reset values
   localparam logic signed [23:0] TARGET_RESET    = -24'sd1001000;
   localparam logic [19:0]        DEADBAND_RESET  = 20'd100;
   localparam logic [9:0]         STEP_RESET      = 10'd10;
   localparam logic [15:0]        BRAKE_MIN_RESET = 16'd2000;
   localparam logic [15:0]        BRAKE_MAX_RESET = 16'd14000;
   localparam logic [15:0]        FEEDER_RESET    = 16'(1000000 / 100);

   // Brake period after reset (75 steps per second)
   localparam logic [15:0] BRAKE_PERIOD_RESET = 16'(1000000 / 75);

   // Smallest period a step generator accepts
   localparam logic [15:0] PERIOD_FLOOR = 16'd2;

   // Raw counts per gram
   localparam int GRAMS_DIV = 1700;

   typedef struct packed {
      logic signed [23:0] target;
      logic [19:0]        deadband;
      logic [9:0]         step;
      logic [15:0]        brake_min;
      logic [15:0]        brake_max;
      logic [15:0]        feeder;
   } cfg_type;

   // Averaging results of one request
   typedef struct packed {
      logic               done;
      logic signed [23:0] mean;
      logic [12:0]        grams;
   } avg_type;

   // Brake regulator state after one request
   typedef struct packed {
      logic [15:0] period;
      logic        running;
   } brk_type;

   typedef struct packed {
      logic [15:0]        brake_period;
      logic [14:0]        brake_compare;
      logic [15:0]        feeder_period_out;
      logic [14:0]        feeder_compare;
      logic signed [23:0] tension_mean;
      logic [12:0]        tension_grams;
      logic               drivers_enabled;
      logic               average_done;
   } rsp_type;

endpackage

FILE: hdl/atdr_if.sv
// Request, response and control channel interfaces of the regulator.
interface atdr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [23:0] sample;

   modport source (output valid, output mode, output sample, input ready);
   modport sink (input valid, input mode, input sample, output ready);
endinterface

interface atdr_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        brake_period;
   logic [14:0]        brake_compare;
   logic [15:0]        feeder_period_out;
   logic [14:0]        feeder_compare;
   logic signed [23:0] tension_mean;
   logic [12:0]        tension_grams;
   logic               drivers_enabled;
   logic               average_done;

   modport source (output valid, output brake_period, output brake_compare,
                   output feeder_period_out, output feeder_compare,
                   output tension_mean, output tension_grams,
                   output drivers_enabled, output average_done, input ready);
   modport sink (input valid, input brake_period, input brake_compare,
                 input feeder_period_out, input feeder_compare,
                 input tension_mean, input tension_grams,
                 input drivers_enabled, input average_done, output ready);
endinterface

interface atdr_csr_if;
   import atdr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/atdr_csr.sv
// Control registers of the regulator, written through the control channel.
module atdr_csr (
   input  logic              clock,
   input  logic              reset,
   atdr_csr_if.sink          csr,
   output atdr_pkg::cfg_type cfg
);
   import atdr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr.ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_TARGET:    cfg_in.target    = $signed(csr.data[23:0]);
            CSR_DEADBAND:  cfg_in.deadband  = csr.data[19:0];
            CSR_STEP:      cfg_in.step      = csr.data[9:0];
            CSR_BRAKE_MIN: cfg_in.brake_min = csr.data[15:0];
            CSR_BRAKE_MAX: cfg_in.brake_max = csr.data[15:0];
            CSR_FEEDER:    cfg_in.feeder    = csr.data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target    <= TARGET_RESET;
         cfg_ff.deadband  <= DEADBAND_RESET;
         cfg_ff.step      <= STEP_RESET;
         cfg_ff.brake_min <= BRAKE_MIN_RESET;
         cfg_ff.brake_max <= BRAKE_MAX_RESET;
         cfg_ff.feeder    <= FEEDER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/atdr_mean.sv
// Sample accumulator with windowed mean and gram conversion.
module atdr_mean #(
   parameter int AVG_COUNT = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [1:0]         mode,
   input  logic signed [23:0] sample,
   output atdr_pkg::avg_type  avg
);
   import atdr_pkg::*;

   localparam int LOG_AVG = $clog2(AVG_COUNT);
   localparam int SUM_W   = 24 + LOG_AVG;
   localparam int CNT_W   = (AVG_COUNT > 1) ? LOG_AVG : 1;
   localparam int PROD_W  = 2 * SUM_W + 1;

   // Exact reciprocals for dividing a SUM_W-bit magnitude by a constant
   localparam int          SH_MEAN  = SUM_W + LOG_AVG;
   localparam logic [SUM_W:0] RCP_MEAN = (SUM_W + 1)'(
      ((longint'(1) << SH_MEAN) + AVG_COUNT - 1) / AVG_COUNT);
   localparam int          GRAMS_D  = AVG_COUNT * GRAMS_DIV;
   localparam int          SH_GRAMS = SUM_W + $clog2(GRAMS_D);
   localparam logic [SUM_W:0] RCP_GRAMS = (SUM_W + 1)'(
      ((longint'(1) << SH_GRAMS) + GRAMS_D - 1) / GRAMS_D);

   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_new;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [23:0]      mean_ff, mean_in, mean_new;
   logic [12:0]             grams_ff, grams_in;
   logic [SUM_W-1:0]        mag;
   logic [PROD_W-1:0]       prod_mean, prod_grams;
   logic [23:0]             quot;
   logic                    is_sample, done;

   assign is_sample = step && (mode == MODE_SAMPLE);
   assign sum_new   = sum_ff + SUM_W'(sample);
   assign done      = is_sample && (count_ff == CNT_W'(AVG_COUNT - 1));

   // Truncating signed divide: divide the magnitude, then restore the sign.
   // Grams divide the sum by the window length times the gram scale at once.
   assign mag        = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
   assign prod_mean  = PROD_W'(mag) * PROD_W'(RCP_MEAN);
   assign prod_grams = PROD_W'(mag) * PROD_W'(RCP_GRAMS);
   assign quot       = prod_mean[SH_MEAN +: 24];
   assign mean_new   = sum_new[SUM_W-1] ? $signed(-quot) : $signed(quot);

   // Window bookkeeping
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      mean_in  = mean_ff;
      grams_in = grams_ff;
      if (done) begin
         sum_in   = '0;
         count_in = '0;
         mean_in  = mean_new;
         grams_in = prod_grams[SH_GRAMS +: 13];
      end else if (is_sample) begin
         sum_in   = sum_new;
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         mean_ff  <= '0;
         grams_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         mean_ff  <= mean_in;
         grams_ff <= grams_in;
      end
   end

   assign avg.done  = done;
   assign avg.mean  = mean_in;
   assign avg.grams = grams_in;

endmodule

FILE: hdl/atdr_brake.sv
// Brake period regulator with deadband, clamping and run control.
module atdr_brake (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [1:0]        mode,
   input  atdr_pkg::avg_type avg,
   input  atdr_pkg::cfg_type cfg,
   output atdr_pkg::brk_type brk
);
   import atdr_pkg::*;

   logic [15:0]        period_ff, period_in;
   logic               running_ff, running_in;
   logic signed [24:0] err, band;
   logic signed [17:0] p_dec, p_inc;

   // Clamp to the limits, minimum tested first, then floor at two
   function automatic logic [15:0] clamp_period(input logic signed [17:0] x,
                                                input logic [15:0] lo,
                                                input logic [15:0] hi);
      logic [15:0] r;
      if (x < $signed({2'b00, lo})) begin
         r = lo;
      end else if (x > $signed({2'b00, hi})) begin
         r = hi;
      end else begin
         r = x[15:0];
      end
      if (r < PERIOD_FLOOR) begin
         r = PERIOD_FLOOR;
      end
      return r;
   endfunction

   assign err   = 25'(cfg.target) - 25'(avg.mean);
   assign band  = $signed({5'b00000, cfg.deadband});
   assign p_dec = $signed({2'b00, period_ff}) - $signed({8'b0, cfg.step});
   assign p_inc = $signed({2'b00, period_ff}) + $signed({8'b0, cfg.step});

   // Next regulator state
   always_comb begin
      period_in  = period_ff;
      running_in = running_ff;
      if (step) begin
         case (mode)
            MODE_SAMPLE: begin
               if (avg.done && running_ff) begin
                  if (err > band) begin
                     period_in = clamp_period(p_dec, cfg.brake_min, cfg.brake_max);
                  end else if (err < -band) begin
                     period_in = clamp_period(p_inc, cfg.brake_min, cfg.brake_max);
                  end else if (period_ff < PERIOD_FLOOR) begin
                     period_in = PERIOD_FLOOR;
                  end
               end
            end
            MODE_START: begin
               if (!running_ff) begin
                  if (period_ff < PERIOD_FLOOR) begin
                     period_in = PERIOD_FLOOR;
                  end
                  running_in = 1'b1;
               end
            end
            MODE_STOP: begin
               running_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= BRAKE_PERIOD_RESET;
         running_ff <= 1'b0;
      end else begin
         period_ff  <= period_in;
         running_ff <= running_in;
      end
   end

   assign brk.period  = period_in;
   assign brk.running = running_in;

endmodule

FILE: hdl/averaged_tension_deadband_regulator.sv
// A request passes the input register and then the response register; a response that
// waits stalls the input stage. Throughput: one request per cycle while responses are
// taken; an input register and a response register decouple the two channels, so one
// more request is taken while a response waits.
// Reset: synchronous; clears both stages, the accumulator and the mean, stops the
// drivers, sets the brake period to 13333 us and loads the register defaults.
module averaged_tension_deadband_regulator #(
   parameter int AVG_COUNT = 10
) (
   input logic        clock,
   input logic        reset,
   atdr_req_if.sink   req,
   atdr_rsp_if.source rsp,
   atdr_csr_if.sink   csr
);
   import atdr_pkg::*;

   cfg_type            cfg;
   avg_type            avg;
   brk_type            brk;
   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_mode_ff;
   logic signed [23:0] in_sample_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               advance;
   logic [15:0]        feed;

   // Handshake: the input stage moves on when the response register is free or being read out
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready    = !in_valid_ff || advance;
   assign in_valid_in  = req.valid ? 1'b1 : (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   atdr_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   atdr_mean #(
      .AVG_COUNT (AVG_COUNT)
   ) u_mean (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .mode   (in_mode_ff),
      .sample (in_sample_ff),
      .avg    (avg)
   );

   atdr_brake u_brake (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .mode  (in_mode_ff),
      .avg   (avg),
      .cfg   (cfg),
      .brk   (brk)
   );

   // Response assembly
   assign feed = (cfg.feeder < PERIOD_FLOOR) ? PERIOD_FLOOR : cfg.feeder;

   always_comb begin
      rsp_in                   = rsp_ff;
      if (advance) begin
         rsp_in.brake_period      = brk.period;
         rsp_in.brake_compare     = brk.period[15:1];
         rsp_in.feeder_period_out = feed;
         rsp_in.feeder_compare    = feed[15:1];
         rsp_in.tension_mean      = avg.mean;
         rsp_in.tension_grams     = avg.grams;
         rsp_in.drivers_enabled   = brk.running;
         rsp_in.average_done      = avg.done;
      end
   end

   // Input and response stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req.valid && req.ready) begin
         in_mode_ff   <= req.mode;
         in_sample_ff <= req.sample;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.brake_period      = rsp_ff.brake_period;
   assign rsp.brake_compare     = rsp_ff.brake_compare;
   assign rsp.feeder_period_out = rsp_ff.feeder_period_out;
   assign rsp.feeder_compare    = rsp_ff.feeder_compare;
   assign rsp.tension_mean      = rsp_ff.tension_mean;
   assign rsp.tension_grams     = rsp_ff.tension_grams;
   assign rsp.drivers_enabled   = rsp_ff.drivers_enabled;
   assign rsp.average_done      = rsp_ff.average_done;

   // Every processed request lands in the response register.
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request did not reach the response register");

   // Only a sensor sample can complete an averaging window.
   a_done_on_sample: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_mode_ff != MODE_SAMPLE)) |=> !rsp_ff.average_done)
      else $error("window completed on a command request");

   // A stop command always leaves the drivers disabled.
   a_stop_disables: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_mode_ff == MODE_STOP)) |=> !rsp_ff.drivers_enabled)
      else $error("drivers still enabled after stop");

   // While running, the reported brake period is never below the floor.
   a_period_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.drivers_enabled) |-> (rsp_ff.brake_period >= PERIOD_FLOOR))
      else $error("brake period below floor while running");

endmodule
